@@ rtl/bmh_pkg.sv @@
package bmh_pkg;

   localparam int DEPTH_DEFAULT      = 128;
   localparam int DATA_WIDTH_DEFAULT = 32;

   typedef enum logic {
      MODE_INSERT = 1'b0,
      MODE_REMOVE = 1'b1
   } mode_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_UP_RD,
      S_UP_CMP,
      S_DN_LAST,
      S_DN_RDL,
      S_DN_RDR,
      S_DN_CMP,
      S_DONE
   } state_type;

   typedef struct packed {
      logic               mode;
      logic signed [31:0] value;
   } req_payload_type;

   typedef struct packed {
      logic signed [31:0] removed_value;
      logic signed [31:0] top_value;
      logic [7:0]         entry_count;
      logic [1:0]         status;
   } rsp_payload_type;

endpackage

@@ rtl/bmh_channels.sv @@
interface bmh_req_if;
   logic                     valid;
   logic                     ready;
   bmh_pkg::req_payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface bmh_rsp_if;
   logic                     valid;
   logic                     ready;
   bmh_pkg::rsp_payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/binary_max_heap_queue.sv @@
// Binary max-heap priority queue.
// req_chan carries one command per transfer: mode 0 inserts value, mode 1
// removes the maximum. rsp_chan returns exactly one result per command:
// the removed value (zero unless a remove succeeded), the new top (zero when
// empty), the entry count and a status (ok, remove on empty, insert on full).
// Entries sit in a single-port-read, single-port-write RAM with a registered
// read; the moving entry is held in a register and each tree level costs a
// read, a compare and a write. An empty remove, a full insert or removing
// the last entry touches no tree level and goes straight to the result.
// req_chan.ready is high only while the sequencer is idle, so a new command
// waits until the one before it has finished.
// The result sits in an output register, so the next command is accepted
// while a finished result still waits; if rsp_chan stalls, a second finished
// result holds the sequencer until the register frees.
// Reset (synchronous, active high) empties the heap at once; RAM contents
// are not cleared, since no entry above the count is ever read.
module binary_max_heap_queue #(
   parameter int DEPTH      = bmh_pkg::DEPTH_DEFAULT,
   parameter int DATA_WIDTH = bmh_pkg::DATA_WIDTH_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   bmh_req_if.sink    req_chan,
   bmh_rsp_if.source  rsp_chan
);

   localparam int IDXW = $clog2(DEPTH + 1);  // tree positions 1..DEPTH
   localparam int AW   = $clog2(DEPTH);      // RAM address = position - 1

   // heap storage
   logic signed [DATA_WIDTH-1:0] heap_mem [DEPTH];
   logic signed [DATA_WIDTH-1:0] rdata_ff;
   logic                         mem_we;
   logic [IDXW-1:0]              wpos;
   logic signed [DATA_WIDTH-1:0] wdata;
   logic [AW-1:0]                raddr;

   // sequencer state
   bmh_pkg::state_type           state_ff, state_in;
   logic [IDXW-1:0]              count_ff, count_in;
   logic [IDXW-1:0]              pos_ff, pos_in;
   logic signed [DATA_WIDTH-1:0] move_ff, move_in;     // entry being sifted
   logic signed [DATA_WIDTH-1:0] top_ff, top_in;       // mirror of the root
   logic signed [DATA_WIDTH-1:0] left_ff, left_in;
   logic                         has_right_ff, has_right_in;
   logic signed [DATA_WIDTH-1:0] removed_ff, removed_in;
   bmh_pkg::status_type          status_ff, status_in;

   // output register
   logic                     rsp_valid_ff, rsp_valid_in;
   bmh_pkg::rsp_payload_type rsp_data_ff, rsp_data_in;

   logic                         req_xfer;
   logic signed [DATA_WIDTH-1:0] req_entry;
   logic [IDXW:0]                left_pos;
   logic [IDXW:0]                right_pos;
   logic [IDXW:0]                count_wide;
   logic signed [DATA_WIDTH-1:0] best_val;
   logic [IDXW-1:0]              best_pos;
   logic signed [63:0]           removed_wide;
   logic signed [63:0]           top_wide;

   assign req_chan.ready = (state_ff == bmh_pkg::S_IDLE);
   assign req_xfer       = req_chan.valid && req_chan.ready;
   // sign-extend the 32-bit command value, then fit it to the entry width
   assign req_entry      = DATA_WIDTH'(64'(req_chan.data.value));

   assign count_wide = {1'b0, count_ff};
   assign left_pos   = {pos_ff, 1'b0};
   assign right_pos  = left_pos + (IDXW+1)'(1);

   assign removed_wide = 64'(removed_ff);
   assign top_wide     = 64'(top_ff);

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.data  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         heap_mem[AW'(wpos - IDXW'(1))] <= wdata;
      end
      rdata_ff <= heap_mem[raddr];
   end

   // largest of moving entry and children; left wins a tie between children
   always_comb begin
      best_val = move_ff;
      best_pos = pos_ff;
      if (left_ff > best_val) begin
         best_val = left_ff;
         best_pos = IDXW'(left_pos);
      end
      if (has_right_ff && (rdata_ff > best_val)) begin
         best_val = rdata_ff;
         best_pos = IDXW'(right_pos);
      end
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      pos_in       = pos_ff;
      move_in      = move_ff;
      top_in       = top_ff;
      left_in      = left_ff;
      has_right_in = has_right_ff;
      removed_in   = removed_ff;
      status_in    = status_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      mem_we       = 1'b0;
      wpos         = pos_ff;
      wdata        = move_ff;
      raddr        = AW'(pos_ff - IDXW'(1));

      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         bmh_pkg::S_IDLE: begin
            if (req_xfer) begin
               removed_in = '0;
               status_in  = bmh_pkg::ST_OK;
               if (req_chan.data.mode == bmh_pkg::MODE_INSERT) begin
                  if (count_ff == IDXW'(DEPTH)) begin
                     status_in = bmh_pkg::ST_FULL;
                     state_in  = bmh_pkg::S_DONE;
                  end else begin
                     count_in = count_ff + IDXW'(1);
                     pos_in   = count_ff + IDXW'(1);
                     move_in  = req_entry;
                     state_in = bmh_pkg::S_UP_RD;
                  end
               end else begin
                  if (count_ff == '0) begin
                     status_in = bmh_pkg::ST_EMPTY;
                     state_in  = bmh_pkg::S_DONE;
                  end else begin
                     removed_in = top_ff;
                     count_in   = count_ff - IDXW'(1);
                     if (count_ff == IDXW'(1)) begin
                        state_in = bmh_pkg::S_DONE;
                     end else begin
                        raddr    = AW'(count_ff - IDXW'(1));  // fetch last entry
                        pos_in   = IDXW'(1);
                        state_in = bmh_pkg::S_DN_LAST;
                     end
                  end
               end
            end
         end

         bmh_pkg::S_UP_RD: begin
            if (pos_ff == IDXW'(1)) begin
               mem_we   = 1'b1;
               top_in   = move_ff;
               state_in = bmh_pkg::S_DONE;
            end else begin
               raddr    = AW'((pos_ff >> 1) - IDXW'(1));
               state_in = bmh_pkg::S_UP_CMP;
            end
         end

         bmh_pkg::S_UP_CMP: begin
            mem_we = 1'b1;
            if (rdata_ff < move_ff) begin
               // parent moves down into the hole
               wdata    = rdata_ff;
               pos_in   = pos_ff >> 1;
               state_in = bmh_pkg::S_UP_RD;
            end else begin
               state_in = bmh_pkg::S_DONE;
            end
         end

         bmh_pkg::S_DN_LAST: begin
            move_in  = rdata_ff;
            state_in = bmh_pkg::S_DN_RDL;
         end

         bmh_pkg::S_DN_RDL: begin
            if (left_pos > count_wide) begin
               mem_we = 1'b1;
               if (pos_ff == IDXW'(1)) begin
                  top_in = move_ff;
               end
               state_in = bmh_pkg::S_DONE;
            end else begin
               raddr    = AW'(left_pos - (IDXW+1)'(1));
               state_in = bmh_pkg::S_DN_RDR;
            end
         end

         bmh_pkg::S_DN_RDR: begin
            left_in      = rdata_ff;
            has_right_in = (right_pos <= count_wide);
            raddr        = AW'(left_pos);
            state_in     = bmh_pkg::S_DN_CMP;
         end

         bmh_pkg::S_DN_CMP: begin
            mem_we = 1'b1;
            wdata  = best_val;
            if (pos_ff == IDXW'(1)) begin
               top_in = best_val;
            end
            if (best_pos == pos_ff) begin
               state_in = bmh_pkg::S_DONE;
            end else begin
               pos_in   = best_pos;
               state_in = bmh_pkg::S_DN_RDL;
            end
         end

         bmh_pkg::S_DONE: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in              = 1'b1;
               rsp_data_in.removed_value = removed_wide[31:0];
               rsp_data_in.top_value     = (count_ff != '0) ? top_wide[31:0] : '0;
               rsp_data_in.entry_count   = 8'(count_ff);
               rsp_data_in.status        = status_ff;
               state_in                  = bmh_pkg::S_IDLE;
            end
         end

         default: begin
            state_in = bmh_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bmh_pkg::S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff       <= pos_in;
      move_ff      <= move_in;
      top_ff       <= top_in;
      left_ff      <= left_in;
      has_right_ff <= has_right_in;
      removed_ff   <= removed_in;
      status_ff    <= status_in;
      rsp_data_ff  <= rsp_data_in;
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= IDXW'(DEPTH))
      else $error("entry count above depth");

   a_write_in_heap: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (wpos != '0) && (wpos <= count_ff))
      else $error("RAM write outside held entries");

   a_busy_after_xfer: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> (state_ff != bmh_pkg::S_IDLE))
      else $error("command accepted without starting work");

   a_empty_remove_keeps: assert property (@(posedge clock) disable iff (reset)
      (req_xfer && (req_chan.data.mode == bmh_pkg::MODE_REMOVE) && (count_ff == '0))
      |=> (count_ff == '0) && (status_ff == bmh_pkg::ST_EMPTY))
      else $error("remove on empty heap changed the count");

   a_result_not_lost: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_chan.ready) |=> rsp_valid_ff)
      else $error("pending result dropped");

endmodule
